[rtl/cack_pkg.sv]
package cack_pkg;

   localparam int SEQ_SPACE = 32768;
   localparam int SEQ_W = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
   localparam int NE_W = SEQ_W + 1;
   localparam int WORD_BITS = (SEQ_SPACE < 32) ? SEQ_SPACE : 32;
   localparam int OFF_W = $clog2(WORD_BITS);
   localparam int ROWS = (SEQ_SPACE + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IN_W = 15;
   localparam int ACK_W = 15;
   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] TOTAL_RESET = 16'd20000;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [OFF_W-1:0] off_type;
   typedef logic [NE_W-1:0] ne_type;

   typedef struct packed {
      logic     en;
      row_type  row;
      word_type data;
   } map_wr_type;

   function automatic row_type row_of(input ne_type pos);
      row_of = ROW_W'(pos >> OFF_W);
   endfunction

   function automatic off_type off_of(input ne_type pos);
      off_of = pos[OFF_W-1:0];
   endfunction

endpackage

[rtl/cumulative_ack_receiver.sv]
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_seq_number[14:0]
// rsp      out  rsp_valid/rsp_stall  rsp_ack_value[14:0], rsp_all_received, rsp_out_of_range
// csr      in   csr_valid/csr_ready  csr_total_count[15:0]
//
// An item passes through accept, mark, scan and emit, and the scan step repeats for each further
// 32-entry bitmap row that the pointer advance crosses; the single bitmap read port sets it.
// After reset the bitmap is swept clear, one row a cycle over all 1024 rows; req_stall stays high.
// A stalled result holds in the output register while the next beat is taken and worked on.
// csr_ready is always high.
module cumulative_ack_receiver
   import cack_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [IN_W-1:0]  req_seq_number,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ACK_W-1:0] rsp_ack_value,
   output logic             rsp_all_received,
   output logic             rsp_out_of_range,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_total_count
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MARK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] total_ff;
   ne_type           ne_ff, ne_in;
   ne_type           start_ff, start_in;
   logic [ACK_W-1:0] last_ack_ff, last_ack_in;
   ne_type           seq_ff, seq_in;
   logic             oor_ff, oor_in;
   logic             fwd_ok_ff, fwd_ok_in;
   row_type          fwd_row_ff, fwd_row_in;
   word_type         fwd_word_ff, fwd_word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ACK_W-1:0] rsp_ack_ff, rsp_ack_in;
   logic             rsp_all_ff, rsp_all_in;
   logic             rsp_oor_ff, rsp_oor_in;

   ne_type           lim;
   logic             req_take;
   logic             slot_free;
   logic             map_busy;
   word_type         rd_word;
   row_type          rd_row;
   map_wr_type       map_wr;
   word_type         scan_word;
   word_type         shifted;
   logic [OFF_W:0]   ones;
   logic [NE_W:0]    sum;
   ne_type           capped;
   logic             run_end;
   word_type         marked;

   cack_map u_map (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_row  (rd_row),
      .rd_word (rd_word),
      .busy    (map_busy)
   );

   assign lim = (32'(total_ff) >= 32'(SEQ_SPACE)) ? NE_W'(SEQ_SPACE) : NE_W'(total_ff);

   assign req_stall = (state_ff != ST_IDLE) || map_busy;
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign marked = rd_word | (word_type'(1) << off_of(seq_ff));

   assign scan_word = (fwd_ok_ff && (fwd_row_ff == row_of(ne_ff))) ? fwd_word_ff : rd_word;
   assign shifted   = scan_word >> off_of(ne_ff);

   always_comb begin
      ones = (OFF_W+1)'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!shifted[i]) begin
            ones = (OFF_W+1)'(i);
         end
      end
   end

   assign sum     = (NE_W+1)'(ne_ff) + (NE_W+1)'(ones);
   assign capped  = (sum >= (NE_W+1)'(lim)) ? lim : NE_W'(sum);
   assign run_end = ((OFF_W+1)'(off_of(ne_ff)) + ones) == (OFF_W+1)'(WORD_BITS);

   always_comb begin
      state_in     = state_ff;
      ne_in        = ne_ff;
      start_in     = start_ff;
      last_ack_in  = last_ack_ff;
      seq_in       = seq_ff;
      oor_in       = oor_ff;
      fwd_ok_in    = fwd_ok_ff;
      fwd_row_in   = fwd_row_ff;
      fwd_word_in  = fwd_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ack_in   = rsp_ack_ff;
      rsp_all_in   = rsp_all_ff;
      rsp_oor_in   = rsp_oor_ff;
      map_wr       = '0;
      rd_row       = row_of(ne_ff);

      case (state_ff)
         ST_IDLE: begin
            seq_in = NE_W'(req_seq_number);
            rd_row = row_of(NE_W'(req_seq_number));
            if (req_take) begin
               oor_in    = 32'(req_seq_number) >= 32'(lim);
               start_in  = ne_ff;
               fwd_ok_in = 1'b0;
               state_in  = ST_MARK;
            end
         end
         ST_MARK: begin
            map_wr.en   = !oor_ff;
            map_wr.row  = row_of(seq_ff);
            map_wr.data = marked;
            fwd_ok_in   = !oor_ff;
            fwd_row_in  = row_of(seq_ff);
            fwd_word_in = marked;
            rd_row      = row_of(ne_ff);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_row = row_of(capped);
            if (ne_ff >= lim) begin
               state_in = ST_EMIT;
            end else begin
               ne_in = capped;
               if (!(run_end && (capped < lim))) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (ne_ff != start_ff) begin
                  last_ack_in = ACK_W'(ne_ff - 1'b1);
               end
               rsp_valid_in = 1'b1;
               rsp_ack_in   = (ne_ff != start_ff) ? ACK_W'(ne_ff - 1'b1) : last_ack_ff;
               rsp_all_in   = ne_ff >= lim;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= TOTAL_RESET;
         ne_ff        <= '0;
         last_ack_ff  <= '0;
         fwd_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ne_ff        <= ne_in;
         last_ack_ff  <= last_ack_in;
         fwd_ok_ff    <= fwd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            total_ff <= csr_total_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      seq_ff      <= seq_in;
      oor_ff      <= oor_in;
      fwd_row_ff  <= fwd_row_in;
      fwd_word_ff <= fwd_word_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_all_ff  <= rsp_all_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ack_value    = rsp_ack_ff;
   assign rsp_all_received = rsp_all_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_no_take_while_clearing: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!map_busy && (state_ff == ST_IDLE)))
      else $error("beat taken while busy or clearing");

   a_ne_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (ne_ff >= $past(ne_ff)))
      else $error("next-expected pointer moved back");

   a_ne_bounded: assert property (@(posedge clock) disable iff (reset)
      (ne_ff != $past(ne_ff)) |-> (ne_ff <= lim))
      else $error("next-expected pointer passed the limit");

   a_write_only_on_mark: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |-> ((state_ff == ST_MARK) && !oor_ff && !map_busy))
      else $error("bitmap written outside the mark step");

   a_emit_loads_slot: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && slot_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("result not loaded on emit");

endmodule

[rtl/cack_map.sv]
module cack_map
   import cack_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  map_wr_type wr,
   input  row_type    rd_row,
   output word_type   rd_word,
   output logic       busy
);

   word_type mem [ROWS];
   word_type rd_word_ff;
   logic     busy_ff;
   row_type  clr_row_ff;

   row_type  wr_row;
   word_type wr_data;
   logic     wr_en;

   always_comb begin
      if (busy_ff) begin
         wr_en   = 1'b1;
         wr_row  = clr_row_ff;
         wr_data = '0;
      end else begin
         wr_en   = wr.en;
         wr_row  = wr.row;
         wr_data = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_row_ff <= '0;
      end else if (busy_ff) begin
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            clr_row_ff <= clr_row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      rd_word_ff <= mem[rd_row];
   end

   assign rd_word = rd_word_ff;
   assign busy    = busy_ff;

endmodule
